// ----- hw/rtl/stcr_pkg.sv -----
package stcr_pkg;

  localparam int unsigned DEFAULT_TRACE_WIDTH    = 256;
  localparam int unsigned DEFAULT_TRACE_HEIGHT   = 128;
  localparam int unsigned DEFAULT_ADC_FULL_SCALE = 4095;
  localparam int unsigned DEFAULT_QUEUE_DEPTH    = 4;

  localparam int unsigned SAMPLE_W = 12;

  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_UP     = 2'd1;
  localparam logic [1:0] FUNC_DOWN   = 2'd2;

  localparam logic KIND_DRAW     = 1'b0;
  localparam logic KIND_TIMEBASE = 1'b1;

  localparam logic [1:0] UNIT_US = 2'd0;
  localparam logic [1:0] UNIT_MS = 2'd1;

  localparam logic [3:0] TB_LAST_INDEX   = 4'd8;
  localparam logic [3:0] TB_MIN_US_INDEX = 4'd2;
  localparam logic [3:0] TB_MAX_MS_INDEX = 4'd6;
  localparam logic [3:0] TB_RESET_INDEX  = 4'd2;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_UP,
    OP_DOWN
  } op_e;

  typedef struct packed {
    logic [1:0]          func;
    logic [SAMPLE_W-1:0] sample;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] column;
    logic [6:0] span_top;
    logic [6:0] span_length;
    logic [8:0] timebase_value;
    logic [1:0] timebase_unit;
  } out_t;

  function automatic logic [8:0] tb_value(logic [3:0] idx);
    logic [8:0] v;
    case (idx)
      4'd0:    v = 9'd1;
      4'd1:    v = 9'd2;
      4'd2:    v = 9'd5;
      4'd3:    v = 9'd10;
      4'd4:    v = 9'd20;
      4'd5:    v = 9'd50;
      4'd6:    v = 9'd100;
      4'd7:    v = 9'd200;
      default: v = 9'd500;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/scope_trace_column_renderer.sv -----
// path: an input passes the input register, the queue, the stage-one register and the output register
// throughput: one item per cycle while out_stall_i is low, set by the input register, queue and two back stages
// the queue between the classifying front and the drawing back absorbs output stalls
// reset: asynchronous, active low; column 0, no previous level, timebase 5 us
// reset empties the queue and pipeline at once, no clearing pass
module scope_trace_column_renderer #(
  parameter int unsigned TRACE_WIDTH    = stcr_pkg::DEFAULT_TRACE_WIDTH,
  parameter int unsigned TRACE_HEIGHT   = stcr_pkg::DEFAULT_TRACE_HEIGHT,
  parameter int unsigned ADC_FULL_SCALE = stcr_pkg::DEFAULT_ADC_FULL_SCALE,
  parameter int unsigned QUEUE_DEPTH    = stcr_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  stcr_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output stcr_pkg::out_t out_data_o
);

  import stcr_pkg::*;

  localparam int unsigned HW = $clog2(TRACE_HEIGHT);
  localparam int unsigned PW = SAMPLE_W + HW;
  localparam int unsigned QW = $bits(op_e) + PW;

  logic          push, full, q_valid, q_pop;
  op_e           f_op;
  logic [PW-1:0] f_prod;
  logic [QW-1:0] q_wdata, q_rdata;

  stcr_front #(
    .TRACE_HEIGHT  (TRACE_HEIGHT),
    .ADC_FULL_SCALE(ADC_FULL_SCALE),
    .PW            (PW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .push_o    (push),
    .full_i    (full),
    .op_o      (f_op),
    .prod_o    (f_prod)
  );

  assign q_wdata = {f_op, f_prod};

  stcr_fifo #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(q_wdata),
    .full_o     (full),
    .valid_o    (q_valid),
    .pop_i      (q_pop),
    .pop_data_o (q_rdata)
  );

  stcr_back #(
    .TRACE_WIDTH   (TRACE_WIDTH),
    .TRACE_HEIGHT  (TRACE_HEIGHT),
    .ADC_FULL_SCALE(ADC_FULL_SCALE),
    .PW            (PW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .q_op_i     (op_e'(q_rdata[QW-1:PW])),
    .q_prod_i   (q_rdata[PW-1:0]),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

// ----- hw/rtl/stcr_fifo.sv -----
module stcr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CNTW'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNTW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hw/rtl/stcr_front.sv -----
module stcr_front #(
  parameter int unsigned TRACE_HEIGHT   = stcr_pkg::DEFAULT_TRACE_HEIGHT,
  parameter int unsigned ADC_FULL_SCALE = stcr_pkg::DEFAULT_ADC_FULL_SCALE,
  parameter int unsigned PW             = 19
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  stcr_pkg::in_t     in_data_i,
  output logic              push_o,
  input  logic              full_i,
  output stcr_pkg::op_e     op_o,
  output logic [PW-1:0]     prod_o
);

  import stcr_pkg::*;

  localparam int unsigned HW = $clog2(TRACE_HEIGHT);
  localparam logic [HW-1:0] HM1 = HW'(TRACE_HEIGHT - 1);
  localparam logic [15:0] FS16 = 16'(ADC_FULL_SCALE);

  logic                f_valid_q, f_valid_d;
  op_e                 f_op_q, op_d;
  logic [PW-1:0]       f_prod_q;
  logic                is_item, accept;
  logic [SAMPLE_W-1:0] clamped;

  assign in_stall_o = f_valid_q && full_i;
  assign push_o     = f_valid_q && !full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign op_o       = f_op_q;
  assign prod_o     = f_prod_q;

  always_comb begin
    is_item = 1'b1;
    op_d    = OP_SAMPLE;
    unique case (in_data_i.func)
      FUNC_SAMPLE: op_d = OP_SAMPLE;
      FUNC_UP:     op_d = OP_UP;
      FUNC_DOWN:   op_d = OP_DOWN;
      default:     is_item = 1'b0;
    endcase
  end

  assign clamped = (16'(in_data_i.sample) > FS16) ? FS16[SAMPLE_W-1:0] : in_data_i.sample;

  always_comb begin
    f_valid_d = f_valid_q;
    if (push_o) begin
      f_valid_d = 1'b0;
    end
    if (accept && is_item) begin
      f_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_item) begin
      f_op_q   <= op_d;
      f_prod_q <= PW'(clamped) * PW'(HM1);
    end
  end

endmodule

// ----- hw/rtl/stcr_back.sv -----
module stcr_back #(
  parameter int unsigned TRACE_WIDTH    = stcr_pkg::DEFAULT_TRACE_WIDTH,
  parameter int unsigned TRACE_HEIGHT   = stcr_pkg::DEFAULT_TRACE_HEIGHT,
  parameter int unsigned ADC_FULL_SCALE = stcr_pkg::DEFAULT_ADC_FULL_SCALE,
  parameter int unsigned PW             = 19
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  output logic           q_pop_o,
  input  stcr_pkg::op_e  q_op_i,
  input  logic [PW-1:0]  q_prod_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output stcr_pkg::out_t out_data_o
);

  import stcr_pkg::*;

  localparam int unsigned HW    = $clog2(TRACE_HEIGHT);
  localparam int unsigned CW    = $clog2(TRACE_WIDTH);
  localparam int unsigned L     = $clog2(ADC_FULL_SCALE);
  localparam int unsigned K     = PW + L;
  localparam int unsigned PRODW = K + HW;
  localparam logic [63:0] M64   =
    ((64'd1 << K) + 64'(ADC_FULL_SCALE) - 64'd1) / 64'(ADC_FULL_SCALE);
  localparam logic [PW:0] MULT  = M64[PW:0];
  localparam logic [HW-1:0] HM1 = HW'(TRACE_HEIGHT - 1);

  logic             s1_valid_q, s1_valid_d;
  op_e              s1_op_q;
  logic [HW-1:0]    s1_level_q;
  logic [PRODW-1:0] recip_prod;
  logic [HW-1:0]    quot;

  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;
  logic             en_out, s1_adv, has_result;

  logic [CW-1:0]    col_q, col_d;
  logic [HW-1:0]    prev_q, prev_d;
  logic             prev_valid_q, prev_valid_d;
  logic [3:0]       tb_idx_q, tb_idx_d;
  logic [1:0]       tb_unit_q, tb_unit_d;
  logic [HW-1:0]    prev_eff, top, len;

  assign en_out      = !out_valid_q || !out_stall_i;
  assign s1_adv      = s1_valid_q && en_out;
  assign q_pop_o     = q_valid_i && (!s1_valid_q || en_out);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // divide by full scale through the reciprocal
  assign recip_prod = PRODW'(q_prod_i) * PRODW'(MULT);
  assign quot       = recip_prod[K +: HW];

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    if (q_pop_o) begin
      s1_valid_d = 1'b1;
    end
  end

  always_comb begin
    prev_eff = prev_valid_q ? prev_q : s1_level_q;
    if (s1_level_q < prev_eff) begin
      top = s1_level_q;
      len = prev_eff - s1_level_q;
    end else if (s1_level_q > prev_eff) begin
      top = prev_eff + HW'(1);
      len = s1_level_q - prev_eff;
    end else begin
      top = s1_level_q;
      len = HW'(1);
    end
  end

  always_comb begin
    col_d        = col_q;
    prev_d       = prev_q;
    prev_valid_d = prev_valid_q;
    tb_idx_d     = tb_idx_q;
    tb_unit_d    = tb_unit_q;
    has_result   = 1'b0;
    out_d        = '0;
    case (s1_op_q)
      OP_SAMPLE: begin
        has_result        = 1'b1;
        out_d.kind        = KIND_DRAW;
        out_d.column      = 8'(col_q);
        out_d.span_top    = 7'(top);
        out_d.span_length = 7'(len);
        col_d        = (col_q == CW'(TRACE_WIDTH - 1)) ? '0 : col_q + CW'(1);
        prev_d       = s1_level_q;
        prev_valid_d = 1'b1;
      end
      OP_UP: begin
        if (!(tb_unit_q >= UNIT_MS && tb_idx_q >= TB_MAX_MS_INDEX)) begin
          has_result = 1'b1;
          if (tb_idx_q < TB_LAST_INDEX) begin
            tb_idx_d = tb_idx_q + 4'd1;
          end else begin
            tb_idx_d  = '0;
            tb_unit_d = tb_unit_q + 2'd1;
          end
        end
      end
      OP_DOWN: begin
        if (!(tb_unit_q == UNIT_US && tb_idx_q <= TB_MIN_US_INDEX)) begin
          has_result = 1'b1;
          if (tb_idx_q != '0) begin
            tb_idx_d = ((tb_idx_q > TB_LAST_INDEX) ? TB_LAST_INDEX : tb_idx_q) - 4'd1;
          end else begin
            tb_idx_d  = TB_LAST_INDEX;
            tb_unit_d = tb_unit_q - 2'd1;
          end
        end
      end
      default: has_result = 1'b0;
    endcase
    if (s1_op_q != OP_SAMPLE) begin
      out_d.kind           = KIND_TIMEBASE;
      out_d.timebase_value = tb_value(tb_idx_d);
      out_d.timebase_unit  = tb_unit_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (en_out) begin
      out_valid_d = s1_valid_q && has_result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      col_q        <= '0;
      prev_q       <= '0;
      prev_valid_q <= 1'b0;
      tb_idx_q     <= TB_RESET_INDEX;
      tb_unit_q    <= UNIT_US;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        col_q        <= col_d;
        prev_q       <= prev_d;
        prev_valid_q <= prev_valid_d;
        tb_idx_q     <= tb_idx_d;
        tb_unit_q    <= tb_unit_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_op_q    <= q_op_i;
      s1_level_q <= HM1 - quot;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

endmodule
